// File: src/sjf_pkg.sv
// Shared types and constants for the shortest-job-first scheduler.
`timescale 1ns / 1ps
package sjf_pkg;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned OUT_W  = 23;
    localparam int unsigned SUM_W  = 29;
    localparam int unsigned IN_W   = 16;

    typedef struct packed {
        logic [IN_W-1:0] arrive_tick;
        logic [IN_W-1:0] run_ticks;
        logic            last_job;
    } sjf_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] job_index;
        logic [OUT_W-1:0] finish_tick;
        logic [OUT_W-1:0] turnaround;
        logic [OUT_W-1:0] wait_time;
        logic [SUM_W-1:0] sum_turnaround;
        logic [SUM_W-1:0] sum_wait;
        logic             final_result;
    } sjf_out_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MIN_ARR,
        ST_SCAN,
        ST_CALC,
        ST_EMIT
    } sjf_state_t;

    // Scan token passed along the cell row.
    typedef struct packed {
        logic            found;
        logic [IDX_W:0]  idx;
        logic [IN_W-1:0] burst;
        logic            any_pend;
        logic [IN_W-1:0] min_arr;
    } sjf_tok_t;
endpackage

// File: src/sjf_cell.sv
// One job cell: holds a job and compares it against the passing scan token.
`timescale 1ns / 1ps
module sjf_cell #(
    parameter int unsigned IDX       = 0
) (
    input  logic                        aclk,
    input  logic                        load_en,
    input  logic [sjf_pkg::IN_W-1:0]    arr_in,
    input  logic [sjf_pkg::IN_W-1:0]    bur_in,
    input  logic                        clr_done,
    input  logic                        set_done,
    input  logic                        active,
    input  logic [sjf_pkg::OUT_W-1:0]   clk_now,
    input  sjf_pkg::sjf_tok_t           tok_in,
    output sjf_pkg::sjf_tok_t           tok_out,
    output logic [sjf_pkg::IN_W-1:0]    arr_out
);
    import sjf_pkg::*;

    logic [IN_W-1:0] arr_reg, bur_reg;
    logic            done_reg;
    logic            pend, ready_job;

    always_ff @(posedge aclk) begin
        if (load_en) begin
            arr_reg <= arr_in;
            bur_reg <= bur_in;
        end
        if (clr_done) begin
            done_reg <= 1'b0;
        end else if (set_done) begin
            done_reg <= 1'b1;
        end
    end

    assign pend      = active && !done_reg;
    assign ready_job = pend && ({{(OUT_W-IN_W){1'b0}}, arr_reg} <= clk_now);
    assign arr_out   = arr_reg;

    always_comb begin
        tok_out = tok_in;
        if (ready_job && (!tok_in.found || bur_reg < tok_in.burst)) begin
            tok_out.found = 1'b1;
            tok_out.burst = bur_reg;
            tok_out.idx   = (IDX_W+1)'(IDX);
        end
        if (pend && (!tok_in.any_pend || arr_reg < tok_in.min_arr)) begin
            tok_out.any_pend = 1'b1;
            tok_out.min_arr  = arr_reg;
        end
    end
endmodule

// File: src/sjf_nonpreemptive_scheduler.sv
// Top level of the non-preemptive shortest-job-first scheduler.
`timescale 1ns / 1ps
// Usage: send one job request per cycle on s_ (arrival, burst, last_job).
// Up to MAX_JOBS jobs are held in a row of cells; extra jobs are dropped.
// The request with last_job set closes the set and starts scheduling; no
// request is taken until the last result of that set is in the m_ register.
// Scheduling: each pick walks a token through the cell row, one register
// stage per group of 8 cells, so a pick is a scan of every group, then a
// compute state and an output state. When no pending job has arrived, the
// same scan yields the earliest pending arrival and the clock jumps there,
// costing one more scan and compute. The first scan of a set finds the
// earliest arrival to start the clock, so the first pick comes from the
// second scan after the last_job request. Results are held in the m_
// register while m_ready is low; the scheduler waits for it. Reset (aresetn
// low, synchronous) clears the job count, clock, totals and the output
// valid; job data is not reset.
// A last_job request with zero jobs stored produces no result.
module sjf_nonpreemptive_scheduler #(
    parameter int unsigned MAX_JOBS  = 64,
    parameter int unsigned TIME_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sjf_pkg::sjf_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sjf_pkg::sjf_out_t m_data
);
    import sjf_pkg::*;

    localparam int unsigned GRP  = 8;
    localparam int unsigned NSEG = (MAX_JOBS + GRP - 1) / GRP;
    localparam int unsigned SW   = $clog2(NSEG + 1);

    sjf_state_t state_reg, state_next;
    logic [IDX_W:0]    cnt_reg, cnt_next;
    logic [IDX_W:0]    fin_reg, fin_next;
    logic [OUT_W-1:0]  now_reg, now_next;
    logic [SUM_W-1:0]  tt_reg, tt_next, tw_reg, tw_next;
    logic [SW-1:0]     seg_reg, seg_next;
    logic              mv_reg, mv_next;
    sjf_out_t          md_reg, md_next;
    logic              init_reg, init_next;
    sjf_tok_t          tok_reg, tok_next;
    logic [IDX_W:0]    pick_reg, pick_next;
    logic [IN_W-1:0]   parr_reg, parr_next, pbur_reg, pbur_next;

    logic [IN_W-1:0] tmask;
    logic [IN_W-1:0] arr_m, bur_m;
    logic            load, clr_done, scan_big;
    sjf_tok_t        tk [0:MAX_JOBS];
    logic [IN_W-1:0] arr_c [0:MAX_JOBS-1];
    logic [OUT_W-1:0] turn_w, wait_w, scan_now;

    assign tmask = (TIME_BITS >= IN_W) ? {IN_W{1'b1}} : IN_W'((1 << TIME_BITS) - 1);
    assign arr_m = s_data.arrive_tick & tmask;
    assign bur_m = s_data.run_ticks & tmask;
    assign s_ready  = (state_reg == ST_LOAD);
    assign load     = s_valid && s_ready && (cnt_reg < (IDX_W+1)'(MAX_JOBS));
    assign clr_done = s_valid && s_ready && s_data.last_job;
    // During the first scan the clock is unknown: compare against zero; any
    // pick found there is ignored and only min_arr is used.
    assign scan_now = init_reg ? '0 : now_reg;
    assign scan_big = init_reg;

    // Segment-serial token walk: only the current segment's output is kept.
    assign tk[0] = tok_reg;
    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        sjf_tok_t tin;
        logic     act, sd;
        assign tin = ((g % GRP) == 0) ? tok_reg : tk[g];
        assign act = ((IDX_W+1)'(g) < cnt_reg) && (SW'(g / GRP) == seg_reg) &&
                     (state_reg == ST_SCAN);
        assign sd  = (state_reg == ST_CALC) && !init_reg && tok_reg.found &&
                     (tok_reg.idx == (IDX_W+1)'(g));
        sjf_cell #(.IDX(g)) u_cell (
            .aclk     (aclk),
            .load_en  (load && (cnt_reg == (IDX_W+1)'(g))),
            .arr_in   (arr_m),
            .bur_in   (bur_m),
            .clr_done (clr_done),
            .set_done (sd),
            .active   (act),
            .clk_now  (scan_big ? '0 : scan_now),
            .tok_in   (tin),
            .tok_out  (tk[g+1]),
            .arr_out  (arr_c[g])
        );
    end

    // Token after the active segment: pick the last cell of that segment.
    sjf_tok_t seg_tok;
    always_comb begin
        seg_tok = tok_reg;
        for (int s = 0; s < NSEG; s++) begin
            if (SW'(s) == seg_reg) begin
                seg_tok = tk[((s + 1) * GRP > MAX_JOBS) ? MAX_JOBS : (s + 1) * GRP];
            end
        end
    end

    assign turn_w = now_reg - {{(OUT_W-IN_W){1'b0}}, parr_reg};
    assign wait_w = turn_w - {{(OUT_W-IN_W){1'b0}}, pbur_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            fin_reg   <= '0;
            now_reg   <= '0;
            tt_reg    <= '0;
            tw_reg    <= '0;
            seg_reg   <= '0;
            mv_reg    <= 1'b0;
            init_reg  <= 1'b0;
            tok_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fin_reg   <= fin_next;
            now_reg   <= now_next;
            tt_reg    <= tt_next;
            tw_reg    <= tw_next;
            seg_reg   <= seg_next;
            mv_reg    <= mv_next;
            init_reg  <= init_next;
            tok_reg   <= tok_next;
        end
        md_reg   <= md_next;
        pick_reg <= pick_next;
        parr_reg <= parr_next;
        pbur_reg <= pbur_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;
        now_next   = now_reg;
        tt_next    = tt_reg;
        tw_next    = tw_reg;
        seg_next   = seg_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        init_next  = init_reg;
        tok_next   = tok_reg;
        pick_next  = pick_reg;
        parr_next  = parr_reg;
        pbur_next  = pbur_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (load) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_data.last_job) begin
                        if (load || cnt_reg != '0) begin
                            state_next = ST_SCAN;
                            init_next  = 1'b1;
                            seg_next   = '0;
                            tok_next   = '0;
                            fin_next   = '0;
                            tt_next    = '0;
                            tw_next    = '0;
                        end else begin
                            cnt_next = '0;
                        end
                    end
                end
            end
            ST_MIN_ARR: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                tok_next = seg_tok;
                if (seg_reg == SW'(NSEG - 1)) begin
                    state_next = ST_CALC;
                end else begin
                    seg_next = seg_reg + 1'b1;
                end
            end
            ST_CALC: begin
                seg_next = '0;
                tok_next = '0;
                if (init_reg || !tok_reg.found) begin
                    // Jump the clock to the earliest pending arrival, rescan.
                    init_next  = 1'b0;
                    now_next   = {{(OUT_W-IN_W){1'b0}}, tok_reg.min_arr};
                    state_next = ST_SCAN;
                end else begin
                    pick_next  = tok_reg.idx;
                    parr_next  = arr_c[tok_reg.idx[IDX_W-1:0]];
                    pbur_next  = tok_reg.burst;
                    now_next   = now_reg + {{(OUT_W-IN_W){1'b0}}, tok_reg.burst};
                    fin_next   = fin_reg + 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!mv_reg || m_ready) begin
                    mv_next                 = 1'b1;
                    md_next.job_index       = pick_reg[IDX_W-1:0];
                    md_next.finish_tick     = now_reg;
                    md_next.turnaround      = turn_w;
                    md_next.wait_time       = wait_w;
                    md_next.sum_turnaround  = tt_reg + SUM_W'(turn_w);
                    md_next.sum_wait        = tw_reg + SUM_W'(wait_w);
                    md_next.final_result    = (fin_reg == cnt_reg);
                    tt_next = tt_reg + SUM_W'(turn_w);
                    tw_next = tw_reg + SUM_W'(wait_w);
                    if (fin_reg == cnt_reg) begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;
endmodule

// File: src/sjf_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
module sjf_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input sjf_pkg::sjf_out_t m_data
);
    import sjf_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.final_result |-> !s_ready)
        else $error("request taken during a set");

    a_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.sum_turnaround >= SUM_W'(m_data.turnaround))
        else $error("turnaround total below item");

    a_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.wait_time <= m_data.turnaround)
        else $error("wait exceeds turnaround");
endmodule

bind sjf_nonpreemptive_scheduler sjf_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// File: verif/sjf_sched_checker.sv
// Checker for the shortest-job-first scheduler: predicts schedules and compares results.
`timescale 1ns / 1ps
module sjf_sched_checker #(
    parameter int unsigned MAX_JOBS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  sjf_pkg::sjf_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  sjf_pkg::sjf_out_t m_data,
    output int                fail_count,
    output int                pending_count,
    output int                result_count,
    output int                set_count
);
    import sjf_pkg::*;

    logic [IN_W-1:0] job_arrival [MAX_JOBS];
    logic [IN_W-1:0] job_burst [MAX_JOBS];
    int unsigned jobs_loaded;
    sjf_out_t schedule_q[$];

    // Run one closed set to completion and queue its results in run order.
    task automatic schedule_set();
        logic [63:0] finished_mask;
        longint unsigned now, turn, wt, tot_turn, tot_wait, best, next_arr;
        int pick;
        int unsigned finished;
        sjf_out_t r;
        finished_mask = '0;
        tot_turn = 0;
        tot_wait = 0;
        finished = 0;
        now = 64'hFFFF_FFFF;
        for (int i = 0; i < jobs_loaded; i++)
            if (job_arrival[i] < now) now = job_arrival[i];
        while (finished < jobs_loaded) begin
            pick = -1;
            best = 0;
            for (int i = 0; i < jobs_loaded; i++) begin
                if (!finished_mask[i] && job_arrival[i] <= now &&
                    (pick < 0 || job_burst[i] < best)) begin
                    pick = i;
                    best = job_burst[i];
                end
            end
            if (pick < 0) begin
                next_arr = 64'hFFFF_FFFF;
                for (int i = 0; i < jobs_loaded; i++)
                    if (!finished_mask[i] && job_arrival[i] < next_arr)
                        next_arr = job_arrival[i];
                now = next_arr;
                continue;
            end
            now += job_burst[pick];
            turn = now - job_arrival[pick];
            wt = turn - job_burst[pick];
            tot_turn += turn;
            tot_wait += wt;
            finished_mask[pick] = 1'b1;
            finished++;
            r.job_index = pick[IDX_W-1:0];
            r.finish_tick = now[OUT_W-1:0];
            r.turnaround = turn[OUT_W-1:0];
            r.wait_time = wt[OUT_W-1:0];
            r.sum_turnaround = tot_turn[SUM_W-1:0];
            r.sum_wait = tot_wait[SUM_W-1:0];
            r.final_result = (finished == jobs_loaded);
            schedule_q.push_back(r);
        end
        jobs_loaded = 0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            jobs_loaded = 0;
            schedule_q.delete();
            fail_count <= 0;
            result_count <= 0;
            set_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (schedule_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    if (m_data !== schedule_q[0]) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p",
                                     schedule_q[0], m_data);
                        fail_count <= fail_count + 1;
                    end
                    void'(schedule_q.pop_front());
                end
            end
            if (s_valid && s_ready) begin
                if (jobs_loaded < MAX_JOBS) begin
                    job_arrival[jobs_loaded] = s_data.arrive_tick;
                    job_burst[jobs_loaded] = s_data.run_ticks;
                    jobs_loaded++;
                end
                if (s_data.last_job) begin
                    schedule_set();
                    set_count <= set_count + 1;
                end
            end
        end
        pending_count = schedule_q.size();
    end
endmodule

// File: verif/tb_sjf_nonpreemptive_scheduler.sv
// Testbench top for the shortest-job-first scheduler: stimulus and verdict.
`timescale 1ns / 1ps
module tb_sjf_nonpreemptive_scheduler;
    import sjf_pkg::*;

    localparam int unsigned MAX_JOBS = 64;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sjf_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sjf_out_t m_data;
    int       fail_count, pending_count, result_count, set_count;
    int       requests_sent = 0;

    always #2 aclk = ~aclk;

    sjf_nonpreemptive_scheduler #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(16)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    sjf_sched_checker #(.MAX_JOBS(MAX_JOBS)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count), .set_count(set_count)
    );

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Send one request: drop valid only for a gap, then hold it until accepted.
    task automatic send_job(input logic [15:0] arr, input logic [15:0] brst,
                            input logic last);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data <= '{arrive_tick: arr, run_ticks: brst, last_job: last};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        requests_sent++;
    endtask

    // Random time value, biased toward edges and small spreads so jobs overlap.
    function automatic logic [15:0] rand_time(input int spread);
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return 16'h0000;
        if (roll == 1) return 16'hFFFF;
        if (roll < 4) return 16'($urandom);
        return 16'($urandom_range(spread));
    endfunction

    // Random set of n jobs; the last request closes it.
    task automatic send_set(input int n, input int spread);
        for (int i = 0; i < n; i++)
            send_job(rand_time(spread), rand_time(spread), i == n - 1);
    endtask

    // Result side: random stalls of the same shape as the request side.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            stall = gap_len();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int n, waited;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: single jobs at the extremes, zero bursts.
        send_job(16'h0000, 16'h0000, 1'b1);
        send_job(16'hFFFF, 16'hFFFF, 1'b1);
        // Ties on burst, idle gap before late arrival, and zero bursts.
        send_job(16'd5, 16'd3, 1'b0);
        send_job(16'd0, 16'd3, 1'b0);
        send_job(16'd1, 16'd3, 1'b0);
        send_job(16'd100, 16'd0, 1'b0);
        send_job(16'd200, 16'd1, 1'b1);
        // Short job arrives while a long one runs (non-preemption).
        send_job(16'd0, 16'hFFFF, 1'b0);
        send_job(16'd1, 16'd1, 1'b0);
        send_job(16'd2, 16'd2, 1'b1);
        // Full store plus overflow requests; the last overflow closes the set.
        for (int i = 0; i < MAX_JOBS + 3; i++)
            send_job(16'hFFFF - i[15:0], 16'hFFFF, i == MAX_JOBS + 2);

        // Random sets, mostly small.
        while (requests_sent < 330) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(MAX_JOBS + 2, 20)
                                         : $urandom_range(8, 1);
            send_set(n, ($urandom_range(1)) ? 30 : 2000);
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending_count != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (100) @(posedge aclk);
        $display("Sent %0d requests in %0d sets, checked %0d results.",
                 requests_sent, set_count, result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
